/* src/http_request_head_parser_defines.svh */
// assertion macros for the http request head parser
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp check failed");

// antecedent implies consequent in the next cycle
`define HRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp check failed");

`endif

/* src/hrp_pkg.sv */
// shared types, constants and method lookup for the http request head parser
package hrp_pkg;

    localparam int MAX_REQUEST_BYTES = 65536;
    localparam int MAX_HEADERS = 64;
    localparam int OFF_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int HC_W = $clog2(MAX_HEADERS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] KIND_REQUEST = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_BODY = 3'd2;
    localparam logic [2:0] KIND_END = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_NO_CRLF = 3'd1;
    localparam logic [2:0] ERR_NO_METHOD = 3'd2;
    localparam logic [2:0] ERR_NO_PATH = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG = 3'd4;
    localparam logic [2:0] ERR_TOO_MANY = 3'd5;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    // method names packed first char in the low byte
    localparam logic [55:0] METHOD_TEXT [8] = '{
        56'h00000000544547,
        56'h00000054534F50,
        56'h00000000545550,
        56'h00004554454C4544,
        56'h00004843544150,
        56'h00000044414548,
        56'h534E4F4954504F,
        56'h00004543415254
    };
    localparam logic [3:0] METHOD_LEN [8] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd7, 4'd5
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  method_code;
        logic [15:0] start_offset;
        logic [15:0] field_length;
        logic [15:0] version_length;
        logic [5:0]  header_index;
        logic [6:0]  header_total;
        logic [2:0]  error_code;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic [3:0] method_lookup(input logic [55:0] chars,
                                                 input logic [3:0] count);
        logic [3:0] code;
        code = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (code == 4'd0 && count == METHOD_LEN[i] && chars == METHOD_TEXT[i])
            begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

/* src/hrp_core.sv */
// input register and per-item parse logic with the request state
module hrp_core
    import hrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic [CNT_W-1:0]  fifo_count,
    output push_t             push,
    output result_t           rec0,
    output result_t           rec1
);

    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_PATH = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_HEADERS = 3'd3;
    localparam logic [2:0] PH_BODY_WAIT = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;
    localparam logic [2:0] PH_DEAD = 3'd6;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    logic [2:0]       phase_reg, phase_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [15:0]      field_start_reg, field_start_next;
    logic [15:0]      path_pos_reg, path_pos_next;
    logic [15:0]      path_length_reg, path_length_next;
    logic [55:0]      mchars_reg, mchars_next;
    logic [3:0]       mcount_reg, mcount_next;
    logic             saw_cr_reg, saw_cr_next;
    logic [HC_W-1:0]  hcount_reg, hcount_next;
    logic [3:0]       mresult_reg, mresult_next;

    logic             fire;
    logic             room;
    logic             eol;
    logic [15:0]      off16;
    logic [15:0]      line_len;
    logic             p_valid;
    logic             f_valid;
    result_t          p_rec;
    result_t          f_rec;

    assign room = fifo_count <= CNT_W'(FIFO_DEPTH - 2);
    assign fire = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign off16 = offset_reg[15:0];
    assign eol = (in_byte_reg == CHAR_LF) && saw_cr_reg;
    assign line_len = off16 - 16'd1 - field_start_reg;

    always_comb
    begin
        phase_next = phase_reg;
        offset_next = offset_reg;
        field_start_next = field_start_reg;
        path_pos_next = path_pos_reg;
        path_length_next = path_length_reg;
        mchars_next = mchars_reg;
        mcount_next = mcount_reg;
        saw_cr_next = saw_cr_reg;
        hcount_next = hcount_reg;
        mresult_next = mresult_reg;
        p_valid = 1'b0;
        p_rec = '0;
        f_valid = 1'b0;
        f_rec = '0;

        if (phase_reg != PH_DEAD)
        begin
            if (offset_reg >= OFF_W'(MAX_REQUEST_BYTES))
            begin
                p_valid = 1'b1;
                p_rec.kind = KIND_ERROR;
                p_rec.error_code = ERR_TOO_LONG;
                phase_next = PH_DEAD;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (eol)
                        begin
                            p_valid = 1'b1;
                            p_rec.kind = KIND_ERROR;
                            p_rec.error_code = ERR_NO_METHOD;
                            phase_next = PH_DEAD;
                        end
                        else if (in_byte_reg == CHAR_SP)
                        begin
                            mresult_next = method_lookup(mchars_reg, mcount_reg);
                            path_pos_next = off16 + 16'd1;
                            phase_next = PH_PATH;
                        end
                        else
                        begin
                            for (int i = 0; i < 7; i++)
                            begin
                                if (mcount_reg == 4'(i))
                                begin
                                    mchars_next[8*i +: 8] = mchars_reg[8*i +: 8] | in_byte_reg;
                                end
                            end
                            if (mcount_reg < 4'd8)
                            begin
                                mcount_next = mcount_reg + 4'd1;
                            end
                        end
                    end
                    PH_PATH:
                    begin
                        if (eol)
                        begin
                            p_valid = 1'b1;
                            p_rec.kind = KIND_ERROR;
                            p_rec.error_code = ERR_NO_PATH;
                            phase_next = PH_DEAD;
                        end
                        else if (in_byte_reg == CHAR_SP)
                        begin
                            path_length_next = off16 - path_pos_reg;
                            field_start_next = off16 + 16'd1;
                            phase_next = PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (eol)
                        begin
                            p_valid = 1'b1;
                            p_rec.kind = KIND_REQUEST;
                            p_rec.method_code = mresult_reg;
                            p_rec.start_offset = path_pos_reg;
                            p_rec.field_length = path_length_reg;
                            p_rec.version_length = line_len;
                            field_start_next = off16 + 16'd1;
                            phase_next = PH_HEADERS;
                        end
                    end
                    PH_HEADERS:
                    begin
                        if (eol)
                        begin
                            if (line_len == 16'd0)
                            begin
                                phase_next = PH_BODY_WAIT;
                            end
                            else if (hcount_reg >= HC_W'(MAX_HEADERS))
                            begin
                                p_valid = 1'b1;
                                p_rec.kind = KIND_ERROR;
                                p_rec.error_code = ERR_TOO_MANY;
                                phase_next = PH_DEAD;
                            end
                            else
                            begin
                                p_valid = 1'b1;
                                p_rec.kind = KIND_HEADER;
                                p_rec.start_offset = field_start_reg;
                                p_rec.field_length = line_len;
                                p_rec.header_index = 6'(hcount_reg);
                                hcount_next = hcount_reg + HC_W'(1);
                            end
                            field_start_next = off16 + 16'd1;
                        end
                    end
                    PH_BODY_WAIT:
                    begin
                        p_valid = 1'b1;
                        p_rec.kind = KIND_BODY;
                        p_rec.start_offset = off16;
                        phase_next = PH_BODY;
                    end
                    default:
                    begin
                    end
                endcase
                saw_cr_next = (in_byte_reg == CHAR_CR);
                offset_next = offset_reg + OFF_W'(1);
            end
        end

        if (in_last_reg)
        begin
            if (phase_next inside {PH_METHOD, PH_PATH, PH_VERSION})
            begin
                f_valid = 1'b1;
                f_rec.kind = KIND_ERROR;
                f_rec.error_code = ERR_NO_CRLF;
            end
            else if (phase_next != PH_DEAD)
            begin
                f_valid = 1'b1;
                f_rec.kind = KIND_END;
                f_rec.header_total = 7'(hcount_next);
            end
            phase_next = PH_METHOD;
            offset_next = '0;
            field_start_next = '0;
            path_pos_next = '0;
            path_length_next = '0;
            mchars_next = '0;
            mcount_next = '0;
            saw_cr_next = 1'b0;
            hcount_next = '0;
            mresult_next = '0;
        end
    end

    always_comb
    begin
        rec0 = p_valid ? p_rec : f_rec;
        rec0.last_of_run = !(p_valid && f_valid);
        rec1 = f_rec;
        rec1.last_of_run = 1'b1;
        push.first = fire && (p_valid || f_valid);
        push.second = fire && p_valid && f_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            offset_reg <= '0;
            field_start_reg <= '0;
            path_pos_reg <= '0;
            path_length_reg <= '0;
            mchars_reg <= '0;
            mcount_reg <= '0;
            saw_cr_reg <= 1'b0;
            hcount_reg <= '0;
            mresult_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            offset_reg <= offset_next;
            field_start_reg <= field_start_next;
            path_pos_reg <= path_pos_next;
            path_length_reg <= path_length_next;
            mchars_reg <= mchars_next;
            mcount_reg <= mcount_next;
            saw_cr_reg <= saw_cr_next;
            hcount_reg <= hcount_next;
            mresult_reg <= mresult_next;
        end
    end

endmodule

/* src/hrp_out_fifo.sv */
// small result queue taking up to two results per cycle
module hrp_out_fifo
    import hrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  push_t            push,
    input  result_t          rec0,
    input  result_t          rec1,
    input  logic             pop,
    output result_t          head,
    output logic [CNT_W-1:0] count
);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] tail_plus;

    assign tail_plus = tail_reg + PTR_W'(1);
    assign head = mem[head_reg];
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                     - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[tail_reg] <= rec0;
        end
        if (push.second)
        begin
            mem[tail_plus] <= rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= head_reg + PTR_W'(1);
            end
            if (push.second)
            begin
                tail_reg <= tail_reg + PTR_W'(2);
            end
            else if (push.first)
            begin
                tail_reg <= tail_plus;
            end
        end
    end

endmodule

/* src/http_request_head_parser.sv */
// top level of the http request head parser
//
// slave channel: one request byte per item in s_tdata, s_tlast on the
// final byte of a request. master channel: result records, kind in
// m_tuser, m_tlast on the last result caused by a byte.
// a byte is held in an input register, parsed combinationally, and its
// zero, one or two results are written into a four-entry result queue.
// the master side reads results from that queue, never straight from
// the parse logic. throughput is one byte per cycle while the receiver
// keeps up; the input register moves on only when the queue holds at
// most two results, so the input stalls only once two-result bytes or
// receiver stalls have filled the queue past that point.
// when the receiver stalls, the queue fills and s_tready drops; nothing
// is lost. a request's last byte returns the parser to its initial
// state and adds an end or error record unless an error ended it.
// reset empties the queue and the input register and clears the parse
// state; s_tready is high right after reset.
`include "http_request_head_parser_defines.svh"

module http_request_head_parser
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // method_code, start_offset, field_length,
                                   // version_length, header_index,
                                   // header_total, error_code, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);

    push_t            push;
    result_t          rec0;
    result_t          rec1;
    result_t          head;
    logic [CNT_W-1:0] fifo_count;
    logic             pop;
    logic             queue_high;
    logic             close_rec;

    hrp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .fifo_count (fifo_count),
        .push       (push),
        .rec0       (rec0),
        .rec1       (rec1)
    );

    hrp_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .rec0  (rec0),
        .rec1  (rec1),
        .pop   (pop),
        .head  (head),
        .count (fifo_count)
    );

    assign m_tvalid = fifo_count != '0;
    assign pop = m_tvalid && m_tready;
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;
    assign m_tdata = {4'd0, head.error_code, head.header_total, head.header_index,
                      head.version_length, head.field_length, head.start_offset,
                      head.method_code};

    assign queue_high = fifo_count > CNT_W'(FIFO_DEPTH - 2);
    assign close_rec = m_tvalid && (m_tuser == KIND_END || m_tuser == KIND_ERROR);

    `HRP_ASSERT_NOW(a_count_bound, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH))
    `HRP_ASSERT_NOW(a_stall_full, !s_tready, queue_high)
    `HRP_ASSERT_NOW(a_close_last, close_rec, m_tlast)
    `HRP_ASSERT_NEXT(a_no_push_overflow, queue_high && !pop, fifo_count >= $past(fifo_count))

endmodule

/* tb/hrp_result_checker.sv */
// result checker for the http request head parser: byte-level parse prediction and compare
`timescale 1ns / 1ps

module hrp_result_checker
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    localparam logic [3:0] METHOD_UNKNOWN = 4'd0;
    localparam int REPORT_CAP = 50;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_HEADERS,
        PH_BODY_WAIT,
        PH_BODY,
        PH_DEAD
    } phase_t;

    phase_t      phase;
    logic [16:0] offset;
    logic [16:0] line_start;
    logic [16:0] path_pos;
    logic [15:0] path_len;
    logic [55:0] method_text;
    logic [3:0]  method_len;
    logic        cr_seen;
    logic [6:0]  hdr_count;
    logic [3:0]  method_code;

    result_t step_results[$];
    result_t expected_records[$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic string method_name(input int idx);
        case (idx)
            0: return "GET";
            1: return "POST";
            2: return "PUT";
            3: return "DELETE";
            4: return "PATCH";
            5: return "HEAD";
            6: return "OPTIONS";
            default: return "TRACE";
        endcase
    endfunction

    function automatic logic [3:0] match_method(input logic [55:0] text,
                                                input logic [3:0] count);
        string name;
        logic [55:0] name_bits;
        logic [3:0] code;
        code = METHOD_UNKNOWN;
        for (int i = 0; i < 8; i++)
        begin
            name = method_name(i);
            name_bits = '0;
            for (int j = 0; j < name.len(); j++)
            begin
                name_bits[8*j +: 8] = name[j];
            end
            if (code == METHOD_UNKNOWN && name.len() == count && name_bits == text)
            begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    task automatic clear_request();
        phase = PH_METHOD;
        offset = '0;
        line_start = '0;
        path_pos = '0;
        path_len = '0;
        method_text = '0;
        method_len = '0;
        cr_seen = 1'b0;
        hdr_count = '0;
        method_code = METHOD_UNKNOWN;
    endtask

    task automatic add_record(input logic [2:0] kind, input logic [3:0] method,
                              input logic [15:0] start, input logic [15:0] flen,
                              input logic [15:0] vlen, input logic [5:0] hidx,
                              input logic [6:0] htot, input logic [2:0] err);
        result_t rec;
        rec.kind = kind;
        rec.method_code = method;
        rec.start_offset = start;
        rec.field_length = flen;
        rec.version_length = vlen;
        rec.header_index = hidx;
        rec.header_total = htot;
        rec.error_code = err;
        rec.last_of_run = 1'b0;
        step_results.push_back(rec);
    endtask

    task automatic abort_request(input logic [2:0] err);
        add_record(KIND_ERROR, METHOD_UNKNOWN, '0, '0, '0, '0, '0, err);
        phase = PH_DEAD;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic eol;
        logic [16:0] off;
        logic [16:0] len;
        result_t rec;
        step_results.delete();
        if (phase != PH_DEAD)
        begin
            if (offset >= 17'(MAX_REQUEST_BYTES))
            begin
                abort_request(ERR_TOO_LONG);
            end
            else
            begin
                off = offset;
                eol = (b == CHAR_LF) && cr_seen;
                case (phase)
                    PH_METHOD:
                    begin
                        if (eol)
                        begin
                            abort_request(ERR_NO_METHOD);
                        end
                        else if (b == CHAR_SP)
                        begin
                            method_code = match_method(method_text, method_len);
                            path_pos = off + 17'd1;
                            phase = PH_PATH;
                        end
                        else
                        begin
                            if (method_len < 4'd7)
                            begin
                                method_text[8*method_len +: 8] = b;
                            end
                            if (method_len < 4'd8)
                            begin
                                method_len = method_len + 4'd1;
                            end
                        end
                    end
                    PH_PATH:
                    begin
                        if (eol)
                        begin
                            abort_request(ERR_NO_PATH);
                        end
                        else if (b == CHAR_SP)
                        begin
                            path_len = 16'(off - path_pos);
                            line_start = off + 17'd1;
                            phase = PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (eol)
                        begin
                            add_record(KIND_REQUEST, method_code, path_pos[15:0], path_len,
                                       16'(off - 17'd1 - line_start), '0, '0, '0);
                            line_start = off + 17'd1;
                            phase = PH_HEADERS;
                        end
                    end
                    PH_HEADERS:
                    begin
                        if (eol)
                        begin
                            len = off - 17'd1 - line_start;
                            if (len == '0)
                            begin
                                phase = PH_BODY_WAIT;
                            end
                            else if (hdr_count >= 7'(MAX_HEADERS))
                            begin
                                abort_request(ERR_TOO_MANY);
                            end
                            else
                            begin
                                add_record(KIND_HEADER, METHOD_UNKNOWN, line_start[15:0],
                                           len[15:0], '0, hdr_count[5:0], '0, '0);
                                hdr_count = hdr_count + 7'd1;
                            end
                            line_start = off + 17'd1;
                        end
                    end
                    PH_BODY_WAIT:
                    begin
                        add_record(KIND_BODY, METHOD_UNKNOWN, off[15:0], '0, '0, '0, '0, '0);
                        phase = PH_BODY;
                    end
                    default:
                    begin
                    end
                endcase
                cr_seen = (b == CHAR_CR);
                offset = off + 17'd1;
            end
        end
        if (fin)
        begin
            if (phase == PH_METHOD || phase == PH_PATH || phase == PH_VERSION)
            begin
                abort_request(ERR_NO_CRLF);
            end
            else if (phase != PH_DEAD)
            begin
                add_record(KIND_END, METHOD_UNKNOWN, '0, '0, '0, '0, hdr_count, '0);
            end
            clear_request();
        end
        foreach (step_results[i])
        begin
            rec = step_results[i];
            rec.last_of_run = (i == step_results.size() - 1);
            expected_records.push_back(rec);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < REPORT_CAP)
        begin
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_record();
        result_t got;
        result_t want;
        got.kind = m_tuser;
        got.method_code = m_tdata[3:0];
        got.start_offset = m_tdata[19:4];
        got.field_length = m_tdata[35:20];
        got.version_length = m_tdata[51:36];
        got.header_index = m_tdata[57:52];
        got.header_total = m_tdata[64:58];
        got.error_code = m_tdata[67:65];
        got.last_of_run = m_tlast;
        if (expected_records.size() == 0)
        begin
            report_mismatch("unexpected record of kind", got.kind, -1);
        end
        else
        begin
            want = expected_records.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.method_code !== want.method_code)
                report_mismatch("method_code", got.method_code, want.method_code);
            if (got.start_offset !== want.start_offset)
                report_mismatch("start_offset", got.start_offset, want.start_offset);
            if (got.field_length !== want.field_length)
                report_mismatch("field_length", got.field_length, want.field_length);
            if (got.version_length !== want.version_length)
                report_mismatch("version_length", got.version_length, want.version_length);
            if (got.header_index !== want.header_index)
                report_mismatch("header_index", got.header_index, want.header_index);
            if (got.header_total !== want.header_total)
                report_mismatch("header_total", got.header_total, want.header_total);
            if (got.error_code !== want.error_code)
                report_mismatch("error_code", got.error_code, want.error_code);
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_request();
            expected_records.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                check_record();
            end
        end
        outstanding <= expected_records.size();
    end

endmodule

/* tb/tb.sv */
// testbench top for the http request head parser: request stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int   mismatches;
    int   outstanding;
    int   cycle_count;
    int   bytes_sent;
    int   ready_hold;
    logic steady;

    logic [7:0] request_bytes[$];

    http_request_head_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hrp_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // mostly short idle stretches, a few long ones
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 2);
        else
            return $urandom_range(10, 50);
    endfunction

    always @(negedge clk)
    begin
        if (steady)
        begin
            m_tready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if ($urandom_range(0, 99) < 65)
        begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1'b0;
            ready_hold = idle_length();
        end
    end

    function automatic string method_name(input int idx);
        case (idx)
            0: return "GET";
            1: return "POST";
            2: return "PUT";
            3: return "DELETE";
            4: return "PATCH";
            5: return "HEAD";
            6: return "OPTIONS";
            default: return "TRACE";
        endcase
    endfunction

    // any nonzero byte but space, cr and lf
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(1, 255));
        end
        while (b == CHAR_SP || b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            request_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_crlf();
        request_bytes.push_back(CHAR_CR);
        request_bytes.push_back(CHAR_LF);
    endtask

    task automatic add_filler(input int n, input logic with_breaks);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (with_breaks && r < 10)
                request_bytes.push_back(CHAR_SP);
            else if (with_breaks && r < 13)
                request_bytes.push_back(CHAR_CR);
            else
                request_bytes.push_back(text_byte());
        end
    endtask

    task automatic build_request(input int headers, input int line_max);
        int r;
        request_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            add_text(method_name($urandom_range(0, 7)));
        end
        else if (r < 80)
        begin
            add_text(method_name($urandom_range(0, 7)));
            add_filler($urandom_range(1, 2), 1'b0);
        end
        else
        begin
            add_filler($urandom_range(0, 9), 1'b0);
        end
        add_text(" ");
        if ($urandom_range(0, 9) != 0)
        begin
            add_text("/");
            add_filler($urandom_range(0, 12), 1'b0);
        end
        add_text(" ");
        if ($urandom_range(0, 4) != 0)
            add_text("HTTP/1.1");
        else
            add_filler($urandom_range(0, 10), 1'b1);
        add_crlf();
        repeat (headers)
        begin
            add_filler($urandom_range(1, line_max), 1'b1);
            add_crlf();
        end
        if ($urandom_range(0, 6) != 0)
        begin
            add_crlf();
            repeat ($urandom_range(0, 8))
            begin
                request_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    task automatic build_noise();
        int r;
        request_bytes.delete();
        repeat ($urandom_range(1, 24))
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                request_bytes.push_back(CHAR_SP);
            else if (r < 30)
                request_bytes.push_back(CHAR_CR);
            else if (r < 45)
                request_bytes.push_back(CHAR_LF);
            else
                request_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_request();
        foreach (request_bytes[i])
        begin
            send_byte(request_bytes[i], i == request_bytes.size() - 1);
            bytes_sent++;
        end
    endtask

    initial
    begin
        int r;
        int keep;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        steady = 1'b0;
        ready_hold = 0;
        cycle_count = 0;
        bytes_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // line end before any space
        request_bytes.delete();
        add_crlf();
        send_request();
        // line end before the path ends
        request_bytes.delete();
        add_text("G ");
        add_crlf();
        send_request();
        // empty method, path and version, zero headers, one body byte
        request_bytes.delete();
        add_text("  ");
        add_crlf();
        add_crlf();
        add_text("Z");
        send_request();
        // single byte request with no line end
        request_bytes.delete();
        request_bytes.push_back(8'hFF);
        send_request();
        // bytes after an error are dropped
        request_bytes.delete();
        add_crlf();
        add_text("X");
        add_crlf();
        send_request();

        while (bytes_sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                build_noise();
            end
            else
            begin
                build_request(($urandom_range(0, 99) < 80) ? $urandom_range(0, 4)
                                                           : $urandom_range(5, 10), 20);
                if (r < 20 && request_bytes.size() > 1)
                begin
                    keep = $urandom_range(1, request_bytes.size() - 1);
                    while (request_bytes.size() > keep) void'(request_bytes.pop_back());
                end
            end
            send_request();
        end

        // header limit reached exactly, then exceeded
        steady = 1'b0;
        build_request(MAX_HEADERS, 3);
        send_request();
        build_request(MAX_HEADERS + 1, 3);
        send_request();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
